FILE: rtl/sfia_pkg.sv
`default_nettype none
package sfia_pkg;

  localparam int TABLE_DEPTH_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_POS_OF = 3'd3;
  localparam logic [2:0] CMD_ID_AT  = 3'd4;
  localparam logic [2:0] CMD_LIST   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] position;
    logic [3:0]  ident;
  } sfia_in_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } sfia_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIND
  } sfia_state_t;

endpackage
`default_nettype wire

FILE: rtl/smallest_free_id_allocator_core.sv
// clear and unused codes give no result; full-table allocate and empty list answer in the
// cycle after start. other commands walk the table memory at one entry a cycle, and a
// lookup hit ends the walk on the cycle it is seen; allocate then scans the used-id
// bitmap for the smallest free id. one item at a time; busy is high while a walk or
// that scan runs.
// results are registered strobes, list gives one per cycle, receiver cannot stall.
// reset (rst_n low, synchronous) empties the table and drops busy and out_strobe.
`default_nettype none
module smallest_free_id_allocator_core #(
  parameter int TABLE_DEPTH   = sfia_pkg::TABLE_DEPTH_DEF,
  parameter int POSITION_BITS = sfia_pkg::POSITION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire sfia_pkg::sfia_in_t in_item,
  output logic                    busy,
  output logic                    out_strobe,
  output sfia_pkg::sfia_out_t     out_item
);
  import sfia_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int PB    = POSITION_BITS;
  localparam int PEXT  = (PB > 16) ? PB : 16;
  localparam int CMP_W = (AW > 4) ? AW : 4;
  localparam int UW    = 2 ** AW;

  // table memory, one port each way
  logic [PB-1:0] pos_mem [TABLE_DEPTH];
  logic [AW-1:0] id_mem  [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [PB-1:0] mem_wpos;
  logic [AW-1:0] mem_wid;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [PB-1:0] rd_pos;
  logic [AW-1:0] rd_id;

  sfia_state_t state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [PB-1:0] opos_r, opos_nxt;
  logic [3:0]    oid_r, oid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] dat_idx_r, dat_idx_nxt;
  logic          found_r, found_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [AW-1:0] cand_r, cand_nxt;
  logic          ov_r, ov_nxt;
  sfia_out_t     od_r, od_nxt;

  logic            accept;
  logic            full;
  logic            issue;
  logic            walk_done;
  logic            hit_id;
  logic            hit_pos;
  logic [PEXT-1:0] in_pos_ext;
  logic [PB-1:0]   in_pos;
  logic [PEXT-1:0] rd_pos_ext;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[mem_wa] <= mem_wpos;
      id_mem[mem_wa]  <= mem_wid;
    end
    if (mem_re) begin
      rd_pos <= pos_mem[mem_ra];
      rd_id  <= id_mem[mem_ra];
    end
  end

  assign accept     = start && (state_r == S_IDLE);
  assign full       = (count_r == CW'(TABLE_DEPTH));
  assign issue      = (rd_idx_r < count_r);
  assign walk_done  = !rv_r && !issue;
  assign hit_id     = rv_r && (CMP_W'(rd_id) == CMP_W'(oid_r));
  assign hit_pos    = rv_r && (rd_pos == opos_r);
  assign in_pos_ext = PEXT'(in_item.position);
  assign in_pos     = in_pos_ext[PB-1:0];
  assign rd_pos_ext = PEXT'(rd_pos);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if ((in_item.command == CMD_ALLOC && !full) ||
              in_item.command == CMD_REMOVE || in_item.command == CMD_POS_OF ||
              in_item.command == CMD_ID_AT ||
              (in_item.command == CMD_LIST && count_r != '0)) begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if ((cmd_r == CMD_POS_OF && hit_id) || (cmd_r == CMD_ID_AT && hit_pos)) begin
          state_nxt = S_IDLE;
        end else if (walk_done) begin
          state_nxt = (cmd_r == CMD_ALLOC) ? S_FIND : S_IDLE;
        end
      end
      S_FIND: begin
        if (!used_r[cand_r]) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt     = cmd_r;
    opos_nxt    = opos_r;
    oid_nxt     = oid_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    rv_nxt      = 1'b0;
    dat_idx_nxt = dat_idx_r;
    found_nxt   = found_r;
    used_nxt    = used_r;
    cand_nxt    = cand_r;
    ov_nxt      = 1'b0;
    od_nxt      = od_r;
    mem_we      = 1'b0;
    mem_wa      = dat_idx_r;
    mem_wpos    = rd_pos;
    mem_wid     = rd_id;
    mem_re      = 1'b0;
    mem_ra      = rd_idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_item.command;
          opos_nxt   = in_pos;
          oid_nxt    = in_item.ident;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          used_nxt   = '0;
          cand_nxt   = '0;
          if (in_item.command == CMD_CLEAR) begin
            count_nxt = '0;
          end else if (in_item.command == CMD_ALLOC && full) begin
            ov_nxt = 1'b1;
            od_nxt = '{value: 16'd0, status: ST_FULL, last: 1'b1};
          end else if (in_item.command == CMD_LIST && count_r == '0) begin
            ov_nxt = 1'b1;
            od_nxt = '{value: 16'd0, status: ST_EMPTY, last: 1'b1};
          end
        end
      end
      S_WALK: begin
        // reads run one entry ahead of the data being handled
        if (issue) begin
          mem_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rv_nxt      = 1'b1;
          dat_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (rv_r) begin
          unique case (cmd_r)
            CMD_ALLOC: used_nxt[rd_id] = 1'b1;
            CMD_REMOVE: begin
              if (!found_r && rd_pos == opos_r) begin
                found_nxt = 1'b1;
              end else begin
                // compact in place, writes trail the reads
                mem_we   = 1'b1;
                mem_wa   = found_r ? (dat_idx_r - AW'(1)) : dat_idx_r;
                mem_wpos = (rd_pos > opos_r) ? (rd_pos - PB'(1)) : rd_pos;
              end
            end
            CMD_POS_OF: begin
              if (hit_id) begin
                ov_nxt = 1'b1;
                od_nxt = '{value: rd_pos_ext[15:0], status: ST_OK, last: 1'b1};
              end
            end
            CMD_ID_AT: begin
              if (hit_pos) begin
                ov_nxt = 1'b1;
                od_nxt = '{value: 16'(rd_id), status: ST_OK, last: 1'b1};
              end
            end
            CMD_LIST: begin
              ov_nxt = 1'b1;
              od_nxt = '{value: 16'(rd_id), status: ST_OK,
                         last: (CW'(dat_idx_r) + CW'(1) == count_r)};
            end
            default: ;
          endcase
        end
        if (walk_done) begin
          if (cmd_r == CMD_REMOVE) begin
            count_nxt = count_r - CW'(found_r);
          end else if (cmd_r == CMD_POS_OF || cmd_r == CMD_ID_AT) begin
            ov_nxt = 1'b1;
            od_nxt = '{value: 16'd0, status: ST_NOT_FOUND, last: 1'b1};
          end
        end
      end
      S_FIND: begin
        // smallest free id is at most count, so the scan stays in range
        if (used_r[cand_r]) begin
          cand_nxt = cand_r + AW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_wa    = count_r[AW-1:0];
          mem_wpos  = opos_r;
          mem_wid   = cand_r;
          count_nxt = count_r + CW'(1);
          ov_nxt    = 1'b1;
          od_nxt    = '{value: 16'(cand_r), status: ST_OK, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    opos_r    <= opos_nxt;
    oid_r     <= oid_nxt;
    rd_idx_r  <= rd_idx_nxt;
    dat_idx_r <= dat_idx_nxt;
    found_r   <= found_nxt;
    used_r    <= used_nxt;
    cand_r    <= cand_nxt;
    od_r      <= od_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = ov_r;
  assign out_item   = od_r;

endmodule
`default_nettype wire

FILE: rtl/sfia_checker.sv
`default_nettype none
module sfia_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire sfia_pkg::sfia_in_t  in_item,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire sfia_pkg::sfia_out_t out_item
);
  import sfia_pkg::*;

  logic acc;
  logic quiet_cmd;
  assign acc       = start && !busy;
  // clear and the unused codes above list
  assign quiet_cmd = (in_item.command == CMD_CLEAR) || (in_item.command > CMD_LIST);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("strobe or busy after reset");

  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && quiet_cmd |=> !busy && !out_strobe)
    else $error("clear or unused code produced activity");

  a_list_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside list run");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != ST_OK |-> out_item.last)
    else $error("error result not final");

  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("list run while idle");

endmodule

bind smallest_free_id_allocator_core sfia_checker u_sfia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .in_item    (in_item),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire
